/* src/b2a_pkg.sv */
// ----------------------------------------------------------------------------
// b2a_pkg: shared types and constants for the BMP to ARGB stream converter
// Holds the dimension limit, field widths, header offsets, result codes and
// the structs passed between the parse stage and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package b2a_pkg;

  // Largest accepted image width or height.
  localparam int MAX_DIM    = 4096;
  // Bits needed for a column/row counter that can also hold MAX_DIM itself.
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int PROD_W     = 2 * DIM_W;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int IDX_W      = 25;
  localparam int POS_W      = 32;

  // BMP header layout.
  localparam int HEADER_LEN = 54;
  localparam int OFS_POS    = 10;
  localparam int COLS_POS   = 18;
  localparam int ROWS_POS   = 22;
  localparam int FIELD_LEN  = 4;

  localparam logic [WORD_W-1:0] ARGB_ALPHA = 16'h8000;
  localparam logic [3:0]        NIB_BLACK  = 4'hC;

  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  typedef enum logic [1:0] {
    KIND_PIXEL        = 2'd0,
    KIND_END_OK       = 2'd1,
    KIND_END_SHORT    = 2'd2,
    KIND_END_OVERSIZE = 2'd3
  } kind_t;

  // Pending work left by one accepted byte: at most a pixel word and an end.
  typedef struct packed {
    logic               pix;
    logic               fin;
    logic               mode;
    kind_t              fin_kind;
    logic [DIM_W-1:0]   flip;
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
    logic [DIM_W-1:0]   col;
    logic [WORD_W-1:0]  word;
  } ev_t;

  // Which pending result the output stage takes this cycle.
  typedef struct packed {
    logic pix;
    logic fin;
  } pop_t;

endpackage

`default_nettype wire

/* src/b2a_in_if.sv */
// ----------------------------------------------------------------------------
// b2a_in_if: byte input channel
// Carries one file byte and its end-of-file marker with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2a_in_if import b2a_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] file_byte;
  logic              is_last;

  modport source (output valid, output file_byte, output is_last, input ready);
  modport sink   (input valid, input file_byte, input is_last, output ready);
endinterface

`default_nettype wire

/* src/b2a_out_if.sv */
// ----------------------------------------------------------------------------
// b2a_out_if: result channel
// Carries one pixel word or end result with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2a_out_if import b2a_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [IDX_W-1:0]  word_index;
  logic [WORD_W-1:0] word;

  modport source (output valid, output kind, output word_index, output word, input ready);
  modport sink   (input valid, input kind, input word_index, input word, output ready);
endinterface

`default_nettype wire

/* src/b2a_front.sv */
// ----------------------------------------------------------------------------
// b2a_front: header capture and pixel assembly
// Tracks the byte position, captures the header fields, groups B,G,R bytes,
// packs pixel words and registers the pending results of each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module b2a_front import b2a_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  b2a_in_if.sink     in_ch,
  input  wire pop_t  pop,
  output ev_t        ev
);

  logic                fmt_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    ofs_r, ofs_nxt;
  logic [POS_W-1:0]    cols_r, cols_nxt;
  logic [POS_W-1:0]    rows_r, rows_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [BYTE_W-1:0]   blue_r, blue_nxt;
  logic [BYTE_W-1:0]   green_r, green_nxt;
  logic [DIM_W-1:0]    col_r, col_nxt;
  logic [DIM_W-1:0]    row_r, row_nxt;
  logic [3:0]          pair_r, pair_nxt;
  ev_t                 ev_r, ev_nxt, ev_new;

  logic [POS_W-1:0]    start;
  logic                oversize;
  logic                active;
  logic                acc;
  logic [BYTE_W-1:0]   b;
  logic [3:0]          nib;
  logic [DIM_W-1:0]    col_inc;

  // The event register may take a new byte once everything in it is delivered.
  assign in_ch.ready = !(ev_r.pix && !pop.pix) && !(ev_r.fin && !pop.fin);
  assign acc         = in_ch.valid && in_ch.ready;
  assign ev          = ev_r;
  assign b           = in_ch.file_byte;

  assign start    = (ofs_r < POS_W'(HEADER_LEN)) ? POS_W'(HEADER_LEN) : ofs_r;
  assign oversize = (cols_r > POS_W'(MAX_DIM)) || (rows_r > POS_W'(MAX_DIM));
  assign active   = (pos_r >= start) && !oversize && (cols_r != '0) &&
                    (row_r < rows_r[DIM_W-1:0]);
  assign nib      = (b[7] | green_r[7] | blue_r[7]) ?
                    {1'b0, b[7], green_r[7], blue_r[7]} : NIB_BLACK;
  assign col_inc  = col_r + DIM_W'(1);

  always_comb begin
    pos_nxt   = (pos_r == '1) ? pos_r : pos_r + POS_W'(1);
    ofs_nxt   = ofs_r;
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    phase_nxt = phase_r;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pair_nxt  = pair_r;

    ev_new          = '0;
    ev_new.mode     = fmt_r;
    ev_new.fin_kind = KIND_END_OK;
    ev_new.flip     = rows_r[DIM_W-1:0] - DIM_W'(1) - row_r;
    ev_new.rows     = rows_r[DIM_W-1:0];
    ev_new.cols     = cols_r[DIM_W-1:0];
    ev_new.col      = col_r;

    for (int k = 0; k < FIELD_LEN; k++) begin
      if (pos_r == POS_W'(OFS_POS + k)) begin
        ofs_nxt[BYTE_W*k +: BYTE_W] = ofs_r[BYTE_W*k +: BYTE_W] | b;
      end
      if (pos_r == POS_W'(COLS_POS + k)) begin
        cols_nxt[BYTE_W*k +: BYTE_W] = cols_r[BYTE_W*k +: BYTE_W] | b;
      end
      if (pos_r == POS_W'(ROWS_POS + k)) begin
        rows_nxt[BYTE_W*k +: BYTE_W] = rows_r[BYTE_W*k +: BYTE_W] | b;
      end
    end

    if (active) begin
      case (phase_r)
        PH_BLUE: begin
          blue_nxt  = b;
          phase_nxt = PH_GREEN;
        end
        PH_GREEN: begin
          green_nxt = b;
          phase_nxt = PH_RED;
        end
        default: begin
          phase_nxt = PH_BLUE;
          if (!fmt_r) begin
            ev_new.pix  = 1'b1;
            ev_new.word = ARGB_ALPHA |
                          {1'b0, b[7:3], green_r[7:3], blue_r[7:3]};
          end else if (!col_r[0]) begin
            pair_nxt = nib;
          end else begin
            ev_new.pix  = 1'b1;
            ev_new.word = {8'h00, nib, pair_r};
          end
          if (col_inc >= cols_r[DIM_W-1:0]) begin
            col_nxt = '0;
            row_nxt = row_r + DIM_W'(1);
          end else begin
            col_nxt = col_inc;
          end
        end
      endcase
    end

    if (in_ch.is_last) begin
      ev_new.fin = 1'b1;
      // The byte count after this byte is below the header length.
      if (pos_r < POS_W'(HEADER_LEN - 1)) begin
        ev_new.fin_kind = KIND_END_SHORT;
      end else if (oversize) begin
        ev_new.fin_kind = KIND_END_OVERSIZE;
      end else begin
        ev_new.fin_kind = KIND_END_OK;
      end
      pos_nxt   = '0;
      ofs_nxt   = '0;
      cols_nxt  = '0;
      rows_nxt  = '0;
      phase_nxt = PH_BLUE;
      blue_nxt  = '0;
      green_nxt = '0;
      col_nxt   = '0;
      row_nxt   = '0;
      pair_nxt  = '0;
    end
  end

  always_comb begin
    if (acc) begin
      ev_nxt = ev_new;
    end else begin
      ev_nxt     = ev_r;
      ev_nxt.pix = ev_r.pix && !pop.pix;
      ev_nxt.fin = ev_r.fin && !pop.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= 1'b0;
      pos_r   <= '0;
      ofs_r   <= '0;
      cols_r  <= '0;
      rows_r  <= '0;
      phase_r <= PH_BLUE;
      blue_r  <= '0;
      green_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      pair_r  <= '0;
      ev_r.pix <= 1'b0;
      ev_r.fin <= 1'b0;
    end else begin
      if (cfg_we) begin
        fmt_r <= cfg_wdata;
      end
      if (acc) begin
        pos_r   <= pos_nxt;
        ofs_r   <= ofs_nxt;
        cols_r  <= cols_nxt;
        rows_r  <= rows_nxt;
        phase_r <= phase_nxt;
        blue_r  <= blue_nxt;
        green_r <= green_nxt;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        pair_r  <= pair_nxt;
      end
      ev_r <= ev_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/b2a_back.sv */
// ----------------------------------------------------------------------------
// b2a_back: index computation and result register
// Forms the row-flipped index or word count with one multiplier and holds
// the result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module b2a_back import b2a_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire ev_t   ev,
  output pop_t       pop,
  b2a_out_if.source  out_ch
);

  logic               out_vld_r, out_vld_nxt;
  logic [1:0]         kind_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [WORD_W-1:0]  word_r;
  logic               take;
  logic [DIM_W-1:0]   mul_a;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  idx_full;

  assign take    = !out_vld_r || out_ch.ready;
  // The pixel word of a byte always leaves before its end result.
  assign pop.pix = take && ev.pix;
  assign pop.fin = take && ev.fin && !ev.pix;

  assign mul_a = ev.pix ? ev.flip : ev.rows;
  assign prod  = PROD_W'(mul_a) * PROD_W'(ev.cols);

  always_comb begin
    if (ev.pix) begin
      idx_full = ev.mode ? (prod >> 1) + PROD_W'(ev.col >> 1) : prod + PROD_W'(ev.col);
    end else if (ev.fin_kind == KIND_END_OK) begin
      idx_full = ev.mode ? (prod >> 1) : prod;
    end else begin
      idx_full = '0;
    end
    idx_nxt = IDX_W'(idx_full);
  end

  always_comb begin
    if (pop.pix || pop.fin) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop.pix) begin
      kind_r <= KIND_PIXEL;
      idx_r  <= idx_nxt;
      word_r <= ev.word;
    end else if (pop.fin) begin
      kind_r <= ev.fin_kind;
      idx_r  <= idx_nxt;
      word_r <= '0;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.word_index = idx_r;
  assign out_ch.word       = word_r;

endmodule

`default_nettype wire

/* src/bmp24_to_argb_stream.sv */
// ----------------------------------------------------------------------------
// bmp24_to_argb_stream: 24-bit BMP byte stream to ARGB pixel words
// Parses the BMP header, converts B,G,R pixels to ARGB1555 words or packed
// ARGB1111 bytes, and tags each with a row-flipped memory index.
// ----------------------------------------------------------------------------
// Usage: the file enters on in_ch one byte per transaction, with is_last set
// on its final byte. Results leave on out_ch: a pixel word (kind 0) with its
// row-flipped index, and on the final byte one end result carrying the word
// count or an error code (header too short, or dimensions above MAX_DIM).
// cfg_we/cfg_wdata set the output format (0 ARGB1555, 1 ARGB1111 pairs); it
// should only be changed between transactions while no result is pending.
// Timing: the edge that accepts a byte loads the event register, and its
// result moves into the result register once that register is free, which
// raises out_ch.valid. Throughput is one byte per cycle while the receiver
// takes results; a final byte that also completes a pixel holds the input
// until both of its results have left through the single result register.
// After a synchronous reset (rst_n low) the parser waits for byte 0 of a new
// file and the format is ARGB1555; the end of every file clears the parser
// the same way. When the receiver stalls, the result register holds. Bytes
// that produce no result keep flowing; the first one that does waits in the
// event register, and in_ch.ready stays low until the receiver takes the
// held result.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_to_argb_stream import b2a_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  b2a_in_if.sink     in_ch,
  b2a_out_if.source  out_ch
);

  ev_t  ev;
  pop_t pop;

  // Header capture, pixel grouping and packing.
  b2a_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .pop       (pop),
    .ev        (ev)
  );

  // Index multiply and the result register.
  b2a_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .ev     (ev),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // The output stage never takes two pending results in one cycle.
  a_pop_single: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop.pix && pop.fin))
    else $error("pixel and end result taken together");

  // An end result only leaves once the pixel of the same byte has gone.
  a_pix_first: assert property (@(posedge clk) disable iff (!rst_n)
    pop.fin |-> (ev.fin && !ev.pix))
    else $error("end result overtook its pixel word");

  // Every accepted final byte leaves an end result pending.
  a_last_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.is_last) |=> ev.fin)
    else $error("final byte without a pending end result");

  // A packed ARGB1111 pair only occupies the low byte.
  a_pair_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (ev.pix && ev.mode) |-> (ev.word[15:8] == 8'h00))
    else $error("ARGB1111 word spills into the high byte");

endmodule

`default_nettype wire
